FILE: rtl/rlf_pkg.sv
// shared types and constants for the rgb linear fade engine
// no dependencies
package rlf_pkg;

   localparam logic [7:0] STEP_MS_RESET = 8'd12;
   localparam logic [7:0] LEVEL_MAX     = 8'hFF;
   localparam int         TIME_W        = 24;
   localparam int         CSR_ADDR_W    = 2;
   localparam int         CSR_DATA_W    = 32;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SET  = 2'd1,
      OP_FADE = 2'd2,
      OP_STOP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_END
   } fsm_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [TIME_W-1:0]  fade_time;
   } req_type;

   typedef struct packed {
      logic [7:0] pwm_red;
      logic [7:0] pwm_green;
      logic [7:0] pwm_blue;
      logic       fading;
   } rsp_type;

   // per-item commands from the sequencer to every lane
   typedef struct packed {
      logic set;
      logic fade;
      logic div_load;
      logic div_step;
      logic fade_end;
      logic tick;
   } lane_ctrl_type;

endpackage

FILE: rtl/rlf_div.sv
// restoring divider, one quotient bit per step
// depends on nothing; iteration count is kept by the caller
module rlf_div #(
   parameter int DW = 32,
   parameter int VW = 24
) (
   input  logic          clock,
   input  logic          load,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   input  logic          step,
   output logic [DW-1:0] quotient
);

   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW:0]   shifted;
   logic [VW:0]   diff;
   logic          ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (load) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (step) begin
         rem_in = ge ? diff[VW-1:0] : shifted[VW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

FILE: rtl/rlf_lane.sv
// one color channel: level, increment, target, pwm and its own divider
// depends on rlf_pkg and rlf_div
module rlf_lane import rlf_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  lane_ctrl_type       ctrl,
   input  logic [7:0]          value,
   input  logic [7:0]          step_ms,
   input  logic [TIME_W-1:0]   fade_time,
   output logic [7:0]          pwm_level,
   output logic                still
);

   localparam int LW = FRAC_BITS + 8;
   localparam int IW = LW + 1;
   localparam int SW = LW + 2;
   localparam int DW = LW + 8;
   localparam logic [LW-1:0] LIM  = {LEVEL_MAX, {FRAC_BITS{1'b0}}};
   localparam logic [LW:0]   HALF = (LW+1)'(1) << (FRAC_BITS - 1);

   logic [LW-1:0]        level_ff, level_in;
   logic signed [IW-1:0] inc_ff, inc_in;
   logic [7:0]           target_ff, target_in;
   logic [7:0]           pwm_ff, pwm_in;
   logic [LW-1:0]        adiff_ff, adiff_in;
   logic                 neg_ff, neg_in;
   logic                 nz_ff, nz_in;

   logic [LW-1:0]        goal_cur, goal_new;
   logic signed [IW-1:0] diff;
   logic signed [IW-1:0] diff_abs;
   logic [DW-1:0]        product;
   logic [DW-1:0]        quotient;
   logic [LW-1:0]        mag;
   logic signed [SW-1:0] sum, goal_s;
   logic                 active, reached;
   logic [LW-1:0]        level_tick;
   logic [LW:0]          rounded;
   logic [8:0]           pwm9;

   rlf_div #(.DW(DW), .VW(TIME_W)) u_div (
      .clock    (clock),
      .load     (ctrl.div_load),
      .dividend (product),
      .divisor  (fade_time),
      .step     (ctrl.div_step),
      .quotient (quotient)
   );

   always_comb begin
      goal_cur = {target_ff, {FRAC_BITS{1'b0}}};
      goal_new = {value, {FRAC_BITS{1'b0}}};
      diff     = $signed({1'b0, goal_new}) - $signed({1'b0, level_ff});
      diff_abs = diff[IW-1] ? -diff : diff;
      product  = {{8{1'b0}}, adiff_ff} * {{LW{1'b0}}, step_ms};

      // a zero fade time gives an all-ones quotient, which saturates below
      if (quotient > DW'(LIM))      mag = LIM;
      else if (quotient == '0)      mag = LW'(1);
      else                          mag = quotient[LW-1:0];

      sum     = $signed({2'b00, level_ff}) + $signed({inc_ff[IW-1], inc_ff});
      goal_s  = $signed({2'b00, goal_cur});
      active  = inc_ff != '0;
      reached = inc_ff[IW-1] ? (sum <= goal_s) : (sum >= goal_s);
      level_tick = reached ? goal_cur : sum[LW-1:0];
      rounded = {1'b0, level_tick} + HALF;
      pwm9    = rounded[LW:FRAC_BITS];
      still   = active && !reached;

      level_in  = level_ff;
      inc_in    = inc_ff;
      target_in = target_ff;
      pwm_in    = pwm_ff;
      adiff_in  = adiff_ff;
      neg_in    = neg_ff;
      nz_in     = nz_ff;

      if (ctrl.set) begin
         target_in = value;
         pwm_in    = value;
         level_in  = goal_new;
         inc_in    = '0;
      end
      if (ctrl.fade) begin
         target_in = value;
         adiff_in  = diff_abs[LW-1:0];
         neg_in    = diff[IW-1];
         nz_in     = diff != '0;
      end
      if (ctrl.fade_end) begin
         if (!nz_ff)      inc_in = '0;
         else if (neg_ff) inc_in = -$signed({1'b0, mag});
         else             inc_in = $signed({1'b0, mag});
      end
      if (ctrl.tick && active) begin
         level_in = level_tick;
         pwm_in   = pwm9[8] ? LEVEL_MAX : pwm9[7:0];
         if (reached) inc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         inc_ff    <= '0;
         target_ff <= '0;
         pwm_ff    <= '0;
      end else begin
         level_ff  <= level_in;
         inc_ff    <= inc_in;
         target_ff <= target_in;
         pwm_ff    <= pwm_in;
      end
   end

   always_ff @(posedge clock) begin
      adiff_ff <= adiff_in;
      neg_ff   <= neg_in;
      nz_ff    <= nz_in;
   end

   assign pwm_level = pwm_ff;

endmodule

FILE: rtl/rgb_linear_fade_engine.sv
// rgb linear fade engine: sequencer, config register, lanes and result merge
// depends on rlf_pkg and rlf_lane
// sequence: a tick, set colour or stop marks a result as owed, and rsp_valid
//   rises once the output register is free; fade to passes through ST_MUL,
//   the one-bit-a-cycle restoring divider in each lane (FRAC_BITS+16 steps)
//   and ST_END; flow: one item at a time; the next item is taken the cycle
//   after the result is loaded into the output register, even if that result
//   still waits
// reset: synchronous, clears levels, targets, increments, fading, step_ms=12
module rgb_linear_fade_engine import rlf_pkg::*; #(
   parameter int CHANNELS  = 3,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // item input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int DW = FRAC_BITS + 16;   // dividend bits = divider steps
   localparam int CW = $clog2(DW);

   fsm_type             state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   logic                fade_active_ff, fade_active_in;
   logic [7:0]          step_ms_ff, step_ms_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   lane_ctrl_type       ctrl;
   logic                accept;
   logic                out_free;
   logic                csr_write;
   logic [7:0]          lane_value [CHANNELS];
   logic [7:0]          lane_pwm   [CHANNELS];
   logic [CHANNELS-1:0] lane_still;
   logic [7:0]          pwm_pad    [3];

   // ---------------- register port ----------------
   // single register at address zero, reads return it at any address
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == '0);
   assign prdata    = {{(CSR_DATA_W-8){1'b0}}, step_ms_ff};
   assign step_ms_in = csr_write ? pwdata[7:0] : step_ms_ff;

   // ---------------- handshake ----------------
   // busy while a fade is being worked out or a result is owed
   assign req_stall = (state_ff != ST_IDLE) || pend_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      pend_in        = pend_ff;
      fade_active_in = fade_active_ff;
      time_in        = time_ff;
      ctrl           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.op)
                  OP_SET: begin
                     ctrl.set       = 1'b1;
                     fade_active_in = 1'b0;
                     pend_in        = 1'b1;
                  end
                  OP_FADE: begin
                     ctrl.fade = 1'b1;
                     time_in   = req_data.fade_time;
                     state_in  = ST_MUL;
                  end
                  OP_STOP: begin
                     fade_active_in = 1'b0;
                     pend_in        = 1'b1;
                  end
                  OP_TICK: begin
                     // lanes only move while a fade runs
                     ctrl.tick = fade_active_ff;
                     if (fade_active_ff) fade_active_in = |lane_still;
                     pend_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            // product step_ms * |diff| goes into each divider
            ctrl.div_load = 1'b1;
            cnt_in        = CW'(DW - 1);
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_END;
         end
         ST_END: begin
            // quotients become signed, saturated increments
            ctrl.fade_end  = 1'b1;
            fade_active_in = 1'b1;
            pend_in        = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // output register: load the owed result once the slot is free
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = pend_ff;
         if (pend_ff) begin
            pend_in = 1'b0;
            rsp_in  = '{pwm_red:   pwm_pad[0],
                        pwm_green: pwm_pad[1],
                        pwm_blue:  pwm_pad[2],
                        fading:    fade_active_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         pend_ff        <= 1'b0;
         fade_active_ff <= 1'b0;
         step_ms_ff     <= STEP_MS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         pend_ff        <= pend_in;
         fade_active_ff <= fade_active_in;
         step_ms_ff     <= step_ms_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- lanes ----------------
   // channels past blue see zero as their value
   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      if (g == 0) begin : g_r
         assign lane_value[g] = req_data.red;
      end else if (g == 1) begin : g_g
         assign lane_value[g] = req_data.green;
      end else if (g == 2) begin : g_b
         assign lane_value[g] = req_data.blue;
      end else begin : g_z
         assign lane_value[g] = 8'h00;
      end

      rlf_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .value     (lane_value[g]),
         .step_ms   (step_ms_ff),
         .fade_time (time_ff),
         .pwm_level (lane_pwm[g]),
         .still     (lane_still[g])
      );
   end

   // ---------------- merge ----------------
   // only the first three channels are reported, missing ones read zero
   for (genvar k = 0; k < 3; k++) begin : g_pad
      if (k < CHANNELS) begin : g_have
         assign pwm_pad[k] = lane_pwm[k];
      end else begin : g_none
         assign pwm_pad[k] = 8'h00;
      end
   end

endmodule

FILE: rtl/rlf_checker.sv
// port-level checks for the rgb linear fade engine, bound to the top level
// depends on rlf_pkg
module rlf_checker import rlf_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_data,
   input logic                  psel,
   input logic                  penable,
   input logic                  pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [CSR_DATA_W-1:0] pwdata,
   input logic [CSR_DATA_W-1:0] prdata
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item in flight: the engine stalls right after taking an item
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while busy");

   // a new result only follows a cycle in which an item was owed
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without an item");

   // register write reads back, upper bits zero
   a_csr_rb: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && paddr == '0 |=>
         prdata[7:0] == $past(pwdata[7:0]) && prdata[CSR_DATA_W-1:8] == '0)
      else $error("step_ms readback mismatch");

endmodule

bind rgb_linear_fade_engine rlf_checker u_rlf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata)
);
